// ===== sv/latency_running_statistics_unit_assert.svh =====
// assertion macros for the latency running statistics unit
`ifndef LATENCY_RUNNING_STATISTICS_UNIT_ASSERT_SVH
`define LATENCY_RUNNING_STATISTICS_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LRSU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrsu assertion failed");

// next-cycle implication, disabled during reset
`define LRSU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrsu assertion failed");

`endif

// ===== sv/lrsu_pkg.sv =====
// package with shared types and constants of the latency statistics unit
`timescale 1ns / 1ps

package lrsu_pkg;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 256;
    localparam int LEN_W      = 16;
    localparam int LAT_IN_W   = 32;
    localparam int BYTES_W    = 48;
    localparam int CNT_OUT_W  = 32;
    localparam int LAT_OUT_W  = 32;
    localparam int MEAN_OUT_W = 48;
    localparam int DEV_W      = 64;
    localparam int MUL_DIGIT  = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MEAN,
        ST_DIFF,
        ST_MUL,
        ST_DEV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic prep;
        logic div_step;
        logic mean_upd;
        logic diff;
        logic mul_step;
        logic dev_upd;
        logic load_out;
    } cmd_t;

endpackage

// ===== sv/lrsu_ctrl.sv =====
// controller state machine sequencing one word through the datapath
`timescale 1ns / 1ps

module lrsu_ctrl #(
    parameter int DIV_STEPS = 48,
    parameter int MUL_STEPS = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output lrsu_pkg::cmd_t cmd
);
    import lrsu_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             valid_reg;
    logic             valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = CNT_W'(DIV_STEPS - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_MEAN;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_MEAN:
            begin
                cmd.mean_upd = 1'b1;
                state_next   = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                cnt_next   = CNT_W'(MUL_STEPS - 1);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_DEV;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_DEV:
            begin
                cmd.dev_upd = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!valid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    assign m_tvalid = valid_reg;

endmodule

// ===== sv/lrsu_datapath.sv =====
// datapath: running figures, iterative divider, digit-serial multiplier
`timescale 1ns / 1ps

module lrsu_datapath #(
    parameter int LATENCY_WIDTH = 32,
    parameter int COUNT_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lrsu_pkg::cmd_t                  cmd,
    input  logic [lrsu_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic [lrsu_pkg::OUT_DATA_W-1:0] m_tdata
);
    import lrsu_pkg::*;

    localparam int LW  = LATENCY_WIDTH;
    localparam int CW  = COUNT_WIDTH;
    localparam int FB  = FRACTION_BITS;
    localparam int MW  = LW + FB;
    localparam int DW  = ((MW + MUL_DIGIT - 1) / MUL_DIGIT) * MUL_DIGIT;
    localparam int PW  = MW + DW;
    localparam int PPW = MW + MUL_DIGIT;

    // architectural state
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [BYTES_W-1:0] bytes_reg;
    logic [BYTES_W-1:0] bytes_next;
    logic [LW-1:0]      min_reg;
    logic [LW-1:0]      min_next;
    logic [LW-1:0]      max_reg;
    logic [LW-1:0]      max_next;
    logic [MW-1:0]      mean_reg;
    logic [MW-1:0]      mean_next;
    logic [DEV_W-1:0]   dev_reg;
    logic [DEV_W-1:0]   dev_next;

    // working registers
    logic [LEN_W-1:0]      len_reg;
    logic [LW-1:0]         lat_reg;
    logic [MW-1:0]         x_reg;
    logic                  up_reg;
    logic [MW-1:0]         dold_reg;
    logic [MW-1:0]         dnew_reg;
    logic [CW-1:0]         rem_reg;
    logic [MW-1:0]         q_reg;
    logic [DW-1:0]         mplr_reg;
    logic [PW-1:0]         acc_reg;
    logic [OUT_DATA_W-1:0] out_reg;

    logic [MW-1:0]      x_cur;
    logic               up_cur;
    logic [MW-1:0]      dold_cur;
    logic [BYTES_W:0]   bytes_sum;
    logic [CW:0]        trial;
    logic               trial_ge;
    logic [CW-1:0]      rem_step;
    logic [PPW-1:0]     pprod;
    logic [PW-1:0]      acc_step;
    logic               dev_over;
    logic [DEV_W-1:0]   dev_add;
    logic [DEV_W:0]     dev_sum;

    assign x_cur    = MW'(lat_reg) << FB;
    assign up_cur   = x_cur >= mean_reg;
    assign dold_cur = up_cur ? (x_cur - mean_reg) : (mean_reg - x_cur);

    assign bytes_sum = (BYTES_W + 1)'(bytes_reg) + (BYTES_W + 1)'(len_reg);

    // restoring division of the deviation by the count, one quotient bit per cycle
    assign trial    = {rem_reg, q_reg[MW-1]};
    assign trial_ge = trial >= {1'b0, count_reg};
    assign rem_step = trial_ge ? CW'(trial - {1'b0, count_reg}) : trial[CW-1:0];

    // product accumulated most significant digit first
    assign pprod    = PPW'(dnew_reg) * PPW'(mplr_reg[DW-1 -: MUL_DIGIT]);
    assign acc_step = (acc_reg << MUL_DIGIT) + PW'(pprod);

    assign dev_over = (acc_reg >> (DEV_W + FB)) != '0;
    assign dev_add  = dev_over ? '1 : DEV_W'(acc_reg >> FB);
    assign dev_sum  = (DEV_W + 1)'(dev_reg) + (DEV_W + 1)'(dev_add);

    always_comb
    begin
        count_next = count_reg;
        bytes_next = bytes_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        mean_next  = mean_reg;
        dev_next   = dev_reg;
        if (cmd.prep)
        begin
            if (count_reg != '1)
                count_next = count_reg + 1'b1;
            bytes_next = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];
            if (lat_reg < min_reg)
                min_next = lat_reg;
            if (lat_reg > max_reg)
                max_next = lat_reg;
        end
        if (cmd.mean_upd)
            mean_next = up_reg ? (mean_reg + q_reg) : (mean_reg - q_reg);
        if (cmd.dev_upd)
            dev_next = dev_sum[DEV_W] ? '1 : dev_sum[DEV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            bytes_reg <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            mean_reg  <= '0;
            dev_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            bytes_reg <= bytes_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            mean_reg  <= mean_next;
            dev_reg   <= dev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            len_reg <= s_tdata[LEN_W-1:0];
            lat_reg <= LW'(s_tdata[LEN_W +: LAT_IN_W]);
        end
        if (cmd.prep)
        begin
            x_reg    <= x_cur;
            up_reg   <= up_cur;
            dold_reg <= dold_cur;
            q_reg    <= dold_cur;
            rem_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_step;
            q_reg   <= {q_reg[MW-2:0], trial_ge};
        end
        if (cmd.diff)
        begin
            dnew_reg <= (x_reg >= mean_reg) ? (x_reg - mean_reg) : (mean_reg - x_reg);
            mplr_reg <= DW'(dold_reg);
            acc_reg  <= '0;
        end
        if (cmd.mul_step)
        begin
            acc_reg  <= acc_step;
            mplr_reg <= mplr_reg << MUL_DIGIT;
        end
        if (cmd.load_out)
        begin
            out_reg <= {dev_reg, MEAN_OUT_W'(mean_reg), LAT_OUT_W'(max_reg),
                        LAT_OUT_W'(min_reg), bytes_reg, CNT_OUT_W'(count_reg)};
        end
    end

    assign m_tdata = out_reg;

endmodule

// ===== sv/latency_running_statistics_unit.sv =====
// a word passes through the prep, divide, mean, difference, multiply and deviation states and is
// loaded into the output register, whose m_tvalid then rises; a new word is taken only in idle,
// after the one-bit-per-cycle divider and the 16-bit-digit multiplier have finished the last one
// a finished result waits in the output register while the next word is taken
// asynchronous active-low reset clears count, bytes, max, mean and deviation sum,
// sets the minimum to all ones and clears m_tvalid; the output data register itself is not reset
`timescale 1ns / 1ps

module latency_running_statistics_unit #(
    parameter int LATENCY_WIDTH = 32,
    parameter int COUNT_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // length_bytes[15:0], latency[47:16]
    input  logic [lrsu_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // packet_count[31:0], byte_total[79:32], latency_min[111:80],
    // latency_max[143:112], latency_mean[191:144], squared_deviation_sum[255:192]
    output logic [lrsu_pkg::OUT_DATA_W-1:0] m_tdata
);
    import lrsu_pkg::*;

    localparam int MW = LATENCY_WIDTH + FRACTION_BITS;

    cmd_t cmd;

    lrsu_ctrl #(
        .DIV_STEPS (MW),
        .MUL_STEPS ((MW + MUL_DIGIT - 1) / MUL_DIGIT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lrsu_datapath #(
        .LATENCY_WIDTH (LATENCY_WIDTH),
        .COUNT_WIDTH   (COUNT_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

// ===== sv/lrsu_checker.sv =====
// port-level checker for the latency statistics unit, bound to the top level
`timescale 1ns / 1ps
`include "latency_running_statistics_unit_assert.svh"

module lrsu_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [255:0] m_tdata
);

    `LRSU_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `LRSU_ASSERT_NXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `LRSU_ASSERT_IMP(a_count_nonzero, clk, rst_n, m_tvalid, m_tdata[31:0] != 32'd0)
    `LRSU_ASSERT_IMP(a_min_le_max, clk, rst_n, m_tvalid, m_tdata[111:80] <= m_tdata[143:112])

endmodule

bind latency_running_statistics_unit lrsu_checker u_checker (.*);
